// ===== design/led_matrix_diff_command_encoder_defines.svh =====
// Assertion macros shared by the LED matrix command encoder RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef LED_MATRIX_DIFF_COMMAND_ENCODER_DEFINES_SVH
`define LED_MATRIX_DIFF_COMMAND_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define LEDMX_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ledmx assertion failed");
// Check a property on every rising clock edge, reset included.
`define LEDMX_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ledmx assertion failed");
`else
`define LEDMX_ASSERT(lbl, clk, rst_n, prop)
`define LEDMX_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== design/ledmx_pkg.sv =====
// Shared types, command codes and helpers of the LED matrix command encoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ledmx_pkg;

  localparam int DEF_COLS = 72;
  localparam int DEF_ROWS = 10;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] OP_CLEAR  = 8'h00;
  localparam logic [7:0] OP_FILL   = 8'h08;
  localparam logic [7:0] OP_PIXEL  = 8'h18;
  localparam logic [7:0] OP_RECT   = 8'h28;

  typedef enum logic [1:0] {
    REQ_PIXEL = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_FILL  = 2'd2,
    REQ_RECT  = 2'd3
  } req_type_e;

  // controller -> datapath
  typedef struct packed {
    logic clr_en;     // write zero at the sweep address, advance the sweep
    logic load;       // capture the incoming request
    logic rd;         // read the shadow at the pixel address
    logic wr_pix;     // write the new level at the pixel address
    logic fill_step;  // write the level at the rectangle cursor, advance it
    logic emit_adv;   // current command byte taken
  } ledmx_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic      clr_done;
    req_type_e req_type;
    logic      pix_ok;
    logic      rect_ok;
    logic      pix_diff;
    logic      fill_last;
    logic      byte_last;
  } ledmx_stat_t;

  // Index of the final byte of each command.
  function automatic logic [2:0] last_idx(req_type_e t);
    logic [2:0] r;
    case (t)
      REQ_PIXEL: r = 3'd4;
      REQ_CLEAR: r = 3'd1;
      REQ_FILL:  r = 3'd2;
      REQ_RECT:  r = 3'd6;
      default:   r = 3'd1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/ledmx_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ledmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 720,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/ledmx_datapath.sv =====
// Datapath: request registers, shadow frame RAM, rectangle cursor and command byte mux.
// Depends on ledmx_pkg, ledmx_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "led_matrix_diff_command_encoder_defines.svh"

module ledmx_datapath #(
  parameter int COLS = ledmx_pkg::DEF_COLS,
  parameter int ROWS = ledmx_pkg::DEF_ROWS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ledmx_pkg::ledmx_cmd_t  cmd_i,
  output ledmx_pkg::ledmx_stat_t      stat_o,
  input  wire logic [31:0]            in_data_i,
  input  wire logic [1:0]             in_user_i,
  output logic [7:0]                  out_byte_o,
  output logic                        out_last_o
);
  import ledmx_pkg::*;

  localparam int Depth = COLS * ROWS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  req_type_e     req_type_q;
  logic [6:0]    col_q, col_end_q, cur_col_q, cur_col_d;
  logic [3:0]    row_q, row_end_q, cur_row_q, cur_row_d;
  logic [7:0]    level_q;
  logic [2:0]    byte_idx_q, byte_idx_d;

  logic [AW-1:0] pix_addr, ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          ram_we;
  logic          pix_ok, rect_ok;
  logic [7:0]    col_plus, rows_minus_row, rows_minus_end, rect_w, rect_h;

  // cursor and counters
  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    byte_idx_d = byte_idx_q;
    if (cmd_i.clr_en) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
    end
    if (cmd_i.load) begin
      cur_col_d  = in_data_i[6:0];
      cur_row_d  = in_data_i[10:7];
      byte_idx_d = 3'd0;
    end else if (cmd_i.fill_step) begin
      if (cur_col_q == col_end_q) begin
        cur_col_d = col_q;
        cur_row_d = cur_row_q + 4'd1;
      end else begin
        cur_col_d = cur_col_q + 7'd1;
      end
    end
    if (cmd_i.emit_adv) begin
      byte_idx_d = stat_o.byte_last ? 3'd0 : byte_idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      cur_col_q  <= '0;
      cur_row_q  <= '0;
      byte_idx_q <= '0;
      req_type_q <= REQ_CLEAR;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      cur_col_q  <= cur_col_d;
      cur_row_q  <= cur_row_d;
      byte_idx_q <= byte_idx_d;
      if (cmd_i.load) begin
        req_type_q <= req_type_e'(in_user_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q     <= in_data_i[6:0];
      row_q     <= in_data_i[10:7];
      col_end_q <= in_data_i[17:11];
      row_end_q <= in_data_i[21:18];
      level_q   <= in_data_i[29:22];
    end
  end

  // shadow frame, row-major
  assign pix_addr  = AW'(32'(cur_row_q) * COLS + 32'(cur_col_q));
  assign ram_addr  = cmd_i.clr_en ? clr_cnt_q : pix_addr;
  assign ram_we    = cmd_i.clr_en | cmd_i.wr_pix | cmd_i.fill_step;
  assign ram_wdata = cmd_i.clr_en ? 8'd0 : level_q;

  ledmx_ram #(
    .WIDTH(8),
    .DEPTH(Depth)
  ) u_shadow (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (cmd_i.rd),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign pix_ok  = (32'(col_q) < COLS) && (32'(row_q) < ROWS);
  assign rect_ok = pix_ok && (32'(col_end_q) < COLS) && (32'(row_end_q) < ROWS) &&
                   (col_end_q >= col_q) && (row_end_q >= row_q);

  assign stat_o.clr_done  = (clr_cnt_q == AW'(Depth - 1));
  assign stat_o.req_type  = req_type_q;
  assign stat_o.pix_ok    = pix_ok;
  assign stat_o.rect_ok   = rect_ok;
  assign stat_o.pix_diff  = (ram_rdata != level_q);
  assign stat_o.fill_last = (cur_col_q == col_end_q) && (cur_row_q == row_end_q);
  assign stat_o.byte_last = (byte_idx_q == last_idx(req_type_q));

  // matrix counts columns from 1 and rows from the bottom
  assign col_plus       = {1'b0, col_q} + 8'd1;
  assign rows_minus_row = 8'(ROWS) - {4'd0, row_q};
  assign rows_minus_end = 8'(ROWS) - {4'd0, row_end_q};
  assign rect_w         = {1'b0, col_end_q} - {1'b0, col_q} + 8'd1;
  assign rect_h         = {4'd0, row_end_q} - {4'd0, row_q} + 8'd1;

  always_comb begin
    out_byte_o = SYNC_BYTE;
    case (req_type_q)
      REQ_PIXEL: begin
        case (byte_idx_q)
          3'd0:    out_byte_o = SYNC_BYTE;
          3'd1:    out_byte_o = OP_PIXEL;
          3'd2:    out_byte_o = col_plus;
          3'd3:    out_byte_o = rows_minus_row;
          default: out_byte_o = level_q;
        endcase
      end
      REQ_CLEAR: begin
        out_byte_o = (byte_idx_q == 3'd0) ? SYNC_BYTE : OP_CLEAR;
      end
      REQ_FILL: begin
        case (byte_idx_q)
          3'd0:    out_byte_o = SYNC_BYTE;
          3'd1:    out_byte_o = OP_FILL;
          default: out_byte_o = level_q;
        endcase
      end
      REQ_RECT: begin
        case (byte_idx_q)
          3'd0:    out_byte_o = SYNC_BYTE;
          3'd1:    out_byte_o = OP_RECT;
          3'd2:    out_byte_o = col_plus;
          3'd3:    out_byte_o = rows_minus_end;
          3'd4:    out_byte_o = rect_w;
          3'd5:    out_byte_o = rect_h;
          default: out_byte_o = level_q;
        endcase
      end
      default: out_byte_o = SYNC_BYTE;
    endcase
  end

  assign out_last_o = stat_o.byte_last;

  `LEDMX_ASSERT(a_fill_in_rect, clk_i, rst_ni,
    cmd_i.fill_step |-> (cur_row_q <= row_end_q && cur_col_q >= col_q && cur_col_q <= col_end_q))
  `LEDMX_ASSERT(a_byte_idx_bound, clk_i, rst_ni, byte_idx_q <= last_idx(req_type_q))
  `LEDMX_ASSERT(a_rd_no_write, clk_i, rst_ni, cmd_i.rd |-> !ram_we)

endmodule

`default_nettype wire

// ===== design/ledmx_ctrl.sv =====
// Controller: sequences the reset sweep, request decode, shadow compare, rectangle
// fill and byte output. Depends on ledmx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ledmx_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ledmx_pkg::ledmx_stat_t stat_i,
  output ledmx_pkg::ledmx_cmd_t       cmd_o,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i
);
  import ledmx_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_DEC   = 6'b000100,
    ST_CMP   = 6'b001000,
    ST_FILL  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (stat_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DEC;
        end
      end
      ST_DEC: begin
        case (stat_i.req_type)
          REQ_PIXEL: begin
            if (stat_i.pix_ok) begin
              cmd_o.rd = 1'b1;
              state_d  = ST_CMP;
            end else begin
              state_d = ST_IDLE;
            end
          end
          REQ_RECT: state_d = stat_i.rect_ok ? ST_FILL : ST_IDLE;
          default:  state_d = ST_EMIT;
        endcase
      end
      ST_CMP: begin
        // unchanged pixel: drop it
        if (stat_i.pix_diff) begin
          cmd_o.wr_pix = 1'b1;
          state_d      = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (stat_i.fill_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.emit_adv = 1'b1;
          if (stat_i.byte_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/led_matrix_diff_command_encoder.sv =====
// Top level of the LED matrix command encoder: shadow-frame diff and command bytes.
// Depends on ledmx_pkg, ledmx_ctrl, ledmx_datapath and the assertion macro header.
//
//   channel  dir  width            contents
//   s_axis   in   tdata 32, tuser 2  pixel / clear / fill / fill-rect request
//   m_axis   out  tdata 8, tlast 1   one command byte, tlast on its final byte
//
// After reset the shadow is swept to zero, all COLS*ROWS entries (720 by default),
// while no request is accepted.
// A changed pixel is accepted, decoded, compared with the shadow and sent as 5 bytes;
// an unchanged pixel ends after the compare; an off-matrix pixel or a dropped rectangle
// ends after decode; clear sends 2 bytes, fill 3. A fill-rect writes width*height
// shadow entries, one entry per cycle, then sends 7 bytes.
// One request at a time; a stalled m_axis holds the byte and blocks s_axis.
`timescale 1ns / 1ps
`default_nettype none
`include "led_matrix_diff_command_encoder_defines.svh"

module led_matrix_diff_command_encoder #(
  parameter int COLS = ledmx_pkg::DEF_COLS,
  parameter int ROWS = ledmx_pkg::DEF_ROWS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // col[6:0], row[10:7], col_end[17:11], row_end[21:18], level[29:22], zero[31:30]
  input  wire logic [31:0] s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_byte[7:0]
  output logic [7:0]       m_axis_tdata,
  // last_byte
  output logic             m_axis_tlast
);
  import ledmx_pkg::*;

  ledmx_cmd_t  cmd;
  ledmx_stat_t stat;

  ledmx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready)
  );

  ledmx_datapath #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .in_data_i (s_axis_tdata),
    .in_user_i (s_axis_tuser),
    .out_byte_o(m_axis_tdata),
    .out_last_o(m_axis_tlast)
  );

  `LEDMX_ASSERT_ALWAYS(a_no_overlap, clk_i, !(s_axis_tready && m_axis_tvalid))
  `LEDMX_ASSERT(a_idle_after_last, clk_i, rst_ni,
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
  `LEDMX_ASSERT(a_out_hold, clk_i, rst_ni,
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for led_matrix_diff_command_encoder: random and directed requests
// against a shadow-frame predictor. Depends on ledmx_pkg and the encoder RTL.
`timescale 1ns / 1ps

module testbench;
  import ledmx_pkg::*;

  localparam int COLS            = DEF_COLS;
  localparam int ROWS            = DEF_ROWS;
  localparam int CELLS           = COLS * ROWS;
  localparam int IDLE_LIMIT      = 20000;
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int ITEMS_PER_PHASE = 85;
  localparam int SETTLE_CYCLES   = 100;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cmd_byte_t;

  // Shadow-frame predictor and the queue of command bytes it still owes.
  class cmd_scoreboard;
    logic [7:0] shadow[CELLS];
    cmd_byte_t  pending[$];
    int         n_reqs;
    int         n_bytes;
    int         n_errors;

    function new();
      foreach (shadow[i]) shadow[i] = '0;
    endfunction

    function void add_byte(logic [7:0] d, logic l);
      pending.push_back(cmd_byte_t'{data: d, last: l});
    endfunction

    function logic [7:0] peek(int idx);
      return shadow[idx];
    endfunction

    // Note one accepted request; return the number of command bytes it owes.
    function int note_request(req_type_e t, logic [6:0] c, logic [3:0] r,
                              logic [6:0] ce, logic [3:0] re, logic [7:0] lv);
      int q0;
      int idx;
      q0 = pending.size();
      n_reqs++;
      case (t)
        REQ_PIXEL: begin
          if (c < COLS && r < ROWS) begin
            idx = int'(r) * COLS + int'(c);
            if (shadow[idx] != lv) begin
              shadow[idx] = lv;
              add_byte(SYNC_BYTE, 1'b0);
              add_byte(OP_PIXEL, 1'b0);
              add_byte(8'(int'(c) + 1), 1'b0);
              add_byte(8'(ROWS - int'(r)), 1'b0);
              add_byte(lv, 1'b1);
            end
          end
        end
        REQ_CLEAR: begin
          add_byte(SYNC_BYTE, 1'b0);
          add_byte(OP_CLEAR, 1'b1);
        end
        REQ_FILL: begin
          add_byte(SYNC_BYTE, 1'b0);
          add_byte(OP_FILL, 1'b0);
          add_byte(lv, 1'b1);
        end
        default: begin
          // drop rectangles that leave the matrix or have reversed ends
          if (c < COLS && ce < COLS && r < ROWS && re < ROWS && ce >= c && re >= r) begin
            for (int rr = int'(r); rr <= int'(re); rr++)
              for (int cc = int'(c); cc <= int'(ce); cc++)
                shadow[rr * COLS + cc] = lv;
            add_byte(SYNC_BYTE, 1'b0);
            add_byte(OP_RECT, 1'b0);
            add_byte(8'(int'(c) + 1), 1'b0);
            add_byte(8'(ROWS - int'(re)), 1'b0);
            add_byte(8'(int'(ce) - int'(c) + 1), 1'b0);
            add_byte(8'(int'(re) - int'(r) + 1), 1'b0);
            add_byte(lv, 1'b1);
          end
        end
      endcase
      return pending.size() - q0;
    endfunction

    function void check_byte(logic [7:0] d, logic l);
      cmd_byte_t want;
      n_bytes++;
      if (pending.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("byte %0d: none expected, got %02h last %0b", n_bytes, d, l);
      end else begin
        want = pending.pop_front();
        if (want.data !== d || want.last !== l) begin
          n_errors++;
          if (n_errors <= 10)
            $display("byte %0d: expected %02h last %0b, got %02h last %0b",
                     n_bytes, want.data, want.last, d, l);
        end
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  cmd_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit rx_hold_req    = 1'b0;
  int idle_cycles    = 0;
  int frame_pos      = 0;

  always #10 clk_i = ~clk_i;

  led_matrix_diff_command_encoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_byte(m_axis_tdata, m_axis_tlast);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one request and return once it is accepted; tvalid stays high for the next one.
  task automatic send_req(input req_type_e t, input int c, input int r, input int ce,
                          input int re, input int lv, output int n);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= t;
    s_axis_tdata  <= {2'b00, 8'(lv), 4'(re), 7'(ce), 4'(r), 7'(c)};
    do @(posedge clk_i); while (!s_axis_tready);
    n = sb.note_request(t, 7'(c), 4'(r), 7'(ce), 4'(re), 8'(lv));
  endtask

  // Pause the sender until every owed byte has come back.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
  endtask

  task automatic random_item(output int n);
    int sel, c, r, ce, re, lv;
    sel = $urandom_range(99);
    c   = $urandom_range(127);
    r   = $urandom_range(15);
    ce  = $urandom_range(127);
    re  = $urandom_range(15);
    lv  = $urandom_range(255);
    if (sel < 55) begin
      // walk the new frame in row-major order; half the pixels repeat the shadow
      frame_pos = (frame_pos + $urandom_range(3, 1)) % CELLS;
      c = frame_pos % COLS;
      r = frame_pos / COLS;
      if ($urandom_range(1) == 1) lv = sb.peek(frame_pos);
      send_req(REQ_PIXEL, c, r, ce, re, lv, n);
    end else if (sel < 70) begin
      c = $urandom_range(COLS - 1);
      r = $urandom_range(ROWS - 1);
      if ($urandom_range(49) == 0) begin
        ce = $urandom_range(COLS - 1, c);
        re = $urandom_range(ROWS - 1, r);
      end else begin
        ce = c + $urandom_range(3);
        re = r + $urandom_range(2);
        if (ce > COLS - 1) ce = COLS - 1;
        if (re > ROWS - 1) re = ROWS - 1;
      end
      send_req(REQ_RECT, c, r, ce, re, lv, n);
    end else if (sel < 76) begin
      send_req(REQ_CLEAR, c, r, ce, re, lv, n);
    end else if (sel < 82) begin
      send_req(REQ_FILL, c, r, ce, re, lv, n);
    end else begin
      case ($urandom_range(2))
        0: begin
          if ($urandom_range(1) == 1) c = $urandom_range(127, COLS);
          else r = $urandom_range(15, ROWS);
          send_req(REQ_PIXEL, c, r, ce, re, lv, n);
        end
        1: send_req(REQ_RECT, c, r, ce, re, lv, n);
        default: send_req(req_type_e'($urandom_range(3)), c, r, ce, re, lv, n);
      endcase
    end
  endtask

  initial begin : stimulus
    int n;
    int n_directed;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // unchanged pixel against the reset shadow, then corners
    send_req(REQ_PIXEL, 0, 0, 127, 15, 8'h00, n);
    send_req(REQ_PIXEL, 0, 0, 0, 0, 8'hFF, n);
    send_req(REQ_PIXEL, COLS - 1, ROWS - 1, 0, 0, 8'h80, n);
    send_req(REQ_PIXEL, COLS - 1, ROWS - 1, 127, 15, 8'h80, n);
    send_req(REQ_PIXEL, 64, 8, 0, 0, 8'h55, n);
    // pixels off the matrix
    send_req(REQ_PIXEL, COLS, 0, 0, 0, 8'h11, n);
    send_req(REQ_PIXEL, 0, ROWS, 0, 0, 8'h22, n);
    send_req(REQ_PIXEL, 127, 15, 127, 15, 8'hAA, n);
    send_req(REQ_CLEAR, 127, 15, 127, 15, 8'hFF, n);
    send_req(REQ_FILL, 0, 0, 0, 0, 8'h00, n);
    send_req(REQ_FILL, 127, 15, 127, 15, 8'hFF, n);
    // whole matrix, then a pixel that now matches the shadow
    send_req(REQ_RECT, 0, 0, COLS - 1, ROWS - 1, 8'h5A, n);
    send_req(REQ_PIXEL, 35, 5, 0, 0, 8'h5A, n);
    send_req(REQ_RECT, COLS - 1, ROWS - 1, COLS - 1, ROWS - 1, 8'h01, n);
    send_req(REQ_RECT, 64, 8, COLS - 1, ROWS - 1, 8'hC3, n);
    // reversed rectangles
    send_req(REQ_RECT, 10, 2, 5, 3, 8'h77, n);
    send_req(REQ_RECT, 2, 6, 4, 5, 8'h77, n);
    // rectangles leaving the matrix
    send_req(REQ_RECT, 0, 0, COLS, 0, 8'h33, n);
    send_req(REQ_RECT, 0, 0, 0, ROWS, 8'h33, n);
    send_req(REQ_RECT, 127, 15, 127, 15, 8'h33, n);
    send_req(REQ_PIXEL, COLS - 1, ROWS - 1, 0, 0, 8'h01, n);
    n_directed = sb.n_reqs;
    wait_drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      // hold the receiver off while requests keep coming, so the input backs up
      if (phase == 0) rx_hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) random_item(n);
      wait_drain();
    end

    recv_stall_pct = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d requests (%0d directed) over four idling phases, %0d bytes checked",
             sb.n_reqs, n_directed, sb.n_bytes);
    $display("mismatches %0d, bytes still owed %0d", sb.n_errors, sb.pending.size());
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/ledmx_pkg.sv
design/ledmx_ram.sv
design/ledmx_datapath.sv
design/ledmx_ctrl.sv
design/led_matrix_diff_command_encoder.sv
verif/testbench.sv
